// ===== rtl/fifo_cache_replacement_core_defines.svh =====
// ----------------------------------------------------------------------------
// fifo_cache_replacement_core_defines
// Assertion macros shared by the replacement core. Each macro checks one
// property on the rising edge of aclk, with checking held off during reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_CACHE_REPLACEMENT_CORE_DEFINES_SVH
`define FIFO_CACHE_REPLACEMENT_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FCR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fcr_pkg.sv =====
// ----------------------------------------------------------------------------
// fcr_pkg
// Types and constants shared by the modules of the replacement core.
// ----------------------------------------------------------------------------
`default_nettype none

package fcr_pkg;

    // default geometry
    localparam int SETS_DEF = 64;
    localparam int WAYS_DEF = 16;

    // field widths on the ports
    localparam int STAMP_W     = 64;
    localparam int SET_IDX_W   = 6;
    localparam int WAY_IDX_W   = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    // request kinds carried on s_tuser
    localparam logic OP_FIND = 1'b0;
    localparam logic OP_FILL = 1'b1;

    // control states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    // controls from the sequencer to the oldest-stamp unit
    typedef struct packed {
        logic compare;
        logic first;
    } scan_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/fifo_cache_replacement_core.sv =====
// ----------------------------------------------------------------------------
// fifo_cache_replacement_core
// FIFO victim choice for a set-associative cache: fill stamps kept in RAM,
// one shared fill counter, oldest-way search per set.
// ----------------------------------------------------------------------------
// After reset the core clears its stamp RAM, one entry a cycle, over all
// SETS*WAYS entries (1024 at the defaults) with s_tready low. On a fill the
// counter is written into the stamp RAM at the addressed set and way and then
// incremented. A find-victim request issues the read of way 0 as it is
// accepted; the single RAM read port then delivers one way's stamp per cycle
// into a running minimum, and the hold state loads the result register once
// it is free. The result register lets a following request start while the
// previous answer waits on m_tready. Fills out of range are dropped; a victim
// request for a set out of range answers way 0.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_cache_replacement_core
    import fcr_pkg::*;
#(
    parameter int SETS = SETS_DEF,
    parameter int WAYS = WAYS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [5:0] set_index, [9:6] fill_way
    input  wire logic                 s_tuser,  // [0] operation
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata   // [3:0] evict_way
);

`include "fifo_cache_replacement_core_defines.svh"

    localparam int DEPTH  = SETS * WAYS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WAY_W  = $clog2(WAYS);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [STAMP_W-1:0]   fill_cnt_reg, fill_cnt_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [WAY_W-1:0]     way_reg, way_next;
    logic                 res_zero_reg, res_zero_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [WAY_IDX_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 in_op;
    logic [SET_IDX_W-1:0] in_set;
    logic [WAY_IDX_W-1:0] in_way;
    logic                 set_ok, way_ok;
    logic [ADDR_W-1:0]    in_base, in_addr;
    logic                 s_acc, out_free, clr_last, scan_last;
    logic [WAY_W-1:0]     scan_way_inc;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [STAMP_W-1:0]   ram_wdata, ram_rdata;
    scan_ctl_t            scan_ctl;
    logic [WAY_W-1:0]     best_way;

    // request decode and stamp address
    assign in_op   = s_tuser;
    assign in_set  = s_tdata[SET_IDX_W-1:0];
    assign in_way  = s_tdata[SET_IDX_W+WAY_IDX_W-1:SET_IDX_W];
    assign set_ok  = (32'(in_set) < 32'(SETS));
    assign way_ok  = (32'(in_way) < 32'(WAYS));
    assign in_base = ADDR_W'(in_set) * ADDR_W'(WAYS);
    assign in_addr = in_base + ADDR_W'(in_way);

    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign clr_last  = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign scan_last = (way_reg == WAY_W'(WAYS - 1));
    assign scan_way_inc = scan_last ? way_reg : (way_reg + 1'b1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc && (in_op == OP_FIND)) begin
                    state_next = set_ok ? ST_SCAN : ST_HOLD;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // state outputs: handshake, RAM ports, scan controls
    always_comb begin
        s_tready         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = in_addr;
        ram_wdata        = fill_cnt_reg;
        ram_raddr        = in_base;
        scan_ctl.compare = 1'b0;
        scan_ctl.first   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_we   = s_acc && (in_op == OP_FILL) && set_ok && way_ok;
            end
            ST_SCAN: begin
                ram_raddr        = base_reg + ADDR_W'(scan_way_inc);
                scan_ctl.compare = 1'b1;
                scan_ctl.first   = (way_reg == '0);
            end
            ST_HOLD: begin
                s_tready = 1'b0;
            end
            default: s_tready = 1'b0;
        endcase
    end

    // datapath registers
    always_comb begin
        clr_addr_next = clr_addr_reg;
        fill_cnt_next = fill_cnt_reg;
        base_next     = base_reg;
        way_next      = way_reg;
        res_zero_next = res_zero_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (state_reg == ST_CLEAR) begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        if ((state_reg == ST_IDLE) && ram_we) begin
            fill_cnt_next = fill_cnt_reg + 1'b1;
        end

        if (s_acc && (in_op == OP_FIND)) begin
            base_next     = in_base;
            way_next      = '0;
            res_zero_next = !set_ok;
        end else if (state_reg == ST_SCAN) begin
            way_next = scan_way_inc;
        end

        // result register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if ((state_reg == ST_HOLD) && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res_zero_reg ? '0 : WAY_IDX_W'(best_way);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            fill_cnt_reg <= '0;
            way_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            fill_cnt_reg <= fill_cnt_next;
            way_reg      <= way_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg     <= base_next;
        res_zero_reg <= res_zero_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // stamp memory
    fcr_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (DEPTH)
    ) u_stamp_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // oldest stamp search
    fcr_oldest #(
        .WAY_W (WAY_W)
    ) u_oldest (
        .aclk     (aclk),
        .scan_ctl (scan_ctl),
        .way      (way_reg),
        .rd_stamp (ram_rdata),
        .best_way (best_way)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - WAY_IDX_W)'(0), m_tdata_reg};

    // checks
    `FCR_ASSERT_SAME(a_no_accept_clear, (state_reg == ST_CLEAR), !s_tready,
        "request accepted during stamp clear")
    `FCR_ASSERT_NEXT(a_fill_counts,
        (s_acc && (in_op == OP_FILL) && set_ok && way_ok),
        (fill_cnt_reg == ($past(fill_cnt_reg) + 64'd1)),
        "fill counter did not advance on a fill")
    `FCR_ASSERT_NEXT(a_result_from_hold,
        (!m_tvalid_reg && (state_reg != ST_HOLD)), !m_tvalid_reg,
        "result raised outside the hold state")
    `FCR_ASSERT_SAME(a_scan_way_range, (state_reg == ST_SCAN),
        (32'(way_reg) < 32'(WAYS)),
        "scan way beyond the set")

endmodule

`default_nettype wire

// ===== rtl/fcr_ram.sv =====
// ----------------------------------------------------------------------------
// fcr_ram
// Generic simple dual-port RAM: one write port, one read port and registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/fcr_oldest.sv =====
// ----------------------------------------------------------------------------
// fcr_oldest
// Running minimum over the stamps of one set, one way per cycle. Strict
// compare keeps the lowest way on equal stamps.
// ----------------------------------------------------------------------------
`default_nettype none

module fcr_oldest
    import fcr_pkg::*;
#(
    parameter int WAY_W = 4
) (
    input  wire logic               aclk,
    input  wire scan_ctl_t          scan_ctl,
    input  wire logic [WAY_W-1:0]   way,
    input  wire logic [STAMP_W-1:0] rd_stamp,
    output logic      [WAY_W-1:0]   best_way
);

    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    logic [WAY_W-1:0]   best_way_reg, best_way_next;

    // take the first way, then any strictly older one
    always_comb begin
        best_stamp_next = best_stamp_reg;
        best_way_next   = best_way_reg;
        if (scan_ctl.compare && (scan_ctl.first || (rd_stamp < best_stamp_reg))) begin
            best_stamp_next = rd_stamp;
            best_way_next   = way;
        end
    end

    always_ff @(posedge aclk) begin
        best_stamp_reg <= best_stamp_next;
        best_way_reg   <= best_way_next;
    end

    assign best_way = best_way_reg;

endmodule

`default_nettype wire

// ===== sim/fifo_cache_replacement_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_cache_replacement_core_test
// Self-checking bench for the FIFO victim choice core. Fill and find-victim
// requests go in on the request stream while a scoreboard keeps its own fill
// stamps and fill counter, predicts each victim way and checks every result
// transaction in order. Both streams idle at random, with one stretch of
// back-to-back traffic.
// ----------------------------------------------------------------------------

module fifo_cache_replacement_core_test;
    import fcr_pkg::*;

    localparam int CLEAR_CYCLES = SETS_DEF * WAYS_DEF;
    localparam int STALL_LIMIT  = CLEAR_CYCLES + 3000;
    localparam int DRAIN_CYCLES = WAYS_DEF + 8;
    localparam int RANDOM_ITEMS = 930;
    localparam int BURST_START  = 300;
    localparam int BURST_END    = 500;

    // predicts victim ways and checks the result stream
    class victim_scoreboard;
        bit [STAMP_W-1:0]   fill_stamp [SETS_DEF][WAYS_DEF];
        bit [STAMP_W-1:0]   fill_count;
        logic [WAY_IDX_W-1:0] victim_queue [$];
        int                 failures;
        int                 reported;

        function new();
            foreach (fill_stamp[s, w]) fill_stamp[s][w] = '0;
            fill_count = '0;
            failures   = 0;
            reported   = 0;
        endfunction

        // note an accepted request; a find queues the predicted victim
        function void note_request(logic op, logic [SET_IDX_W-1:0] set_idx,
                                   logic [WAY_IDX_W-1:0] way_idx);
            logic [WAY_IDX_W-1:0] oldest;
            bit [STAMP_W-1:0]     oldest_stamp;
            if (op == OP_FILL) begin
                if (set_idx < SETS_DEF && way_idx < WAYS_DEF) begin
                    fill_stamp[set_idx][way_idx] = fill_count;
                    fill_count = fill_count + 1'b1;
                end
            end else begin
                oldest = '0;
                if (set_idx < SETS_DEF) begin
                    oldest_stamp = fill_stamp[set_idx][0];
                    // strict less-than keeps the lowest way on ties
                    for (int w = 1; w < WAYS_DEF; w++) begin
                        if (fill_stamp[set_idx][w] < oldest_stamp) begin
                            oldest_stamp = fill_stamp[set_idx][w];
                            oldest = WAY_IDX_W'(w);
                        end
                    end
                end
                victim_queue.push_back(oldest);
            end
        endfunction

        // compare one result transaction with the oldest prediction
        function void check_result(logic [WAY_IDX_W-1:0] got);
            logic [WAY_IDX_W-1:0] want;
            if (victim_queue.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected result: evict_way %0d with nothing pending", got);
                end
            end else begin
                want = victim_queue.pop_front();
                if (got !== want) begin
                    failures++;
                    if (reported < 10) begin
                        reported++;
                        $display("evict_way mismatch: expected %0d, got %0d", want, got);
                    end
                end
            end
        endfunction

        function int pending();
            return victim_queue.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    victim_scoreboard board;
    bit               idle_on;
    int               quiet_cycles;

    fifo_cache_replacement_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [5:0] set_index, [9:6] fill_way
        .s_tuser  (s_tuser),   // [0] operation
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [3:0] evict_way
    );

    // 4 ns clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver side backpressure
    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= !(idle_on && $urandom_range(0, 99) < 11);
    end

    // transaction monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                board.check_result(m_tdata[WAY_IDX_W-1:0]);
            if (s_tvalid && s_tready)
                board.note_request(s_tuser, s_tdata[SET_IDX_W-1:0],
                                   s_tdata[SET_IDX_W +: WAY_IDX_W]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // drive one request; called at a falling edge, returns at a falling edge
    task automatic send_request(logic op, int set_idx, int way_idx);
        while (idle_on && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - SET_IDX_W - WAY_IDX_W){1'b0}},
                     WAY_IDX_W'(way_idx), SET_IDX_W'(set_idx)};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        @(negedge aclk);
    endtask

    initial begin
        int hot_set [4];
        int set_pick;
        int leftover;

        board        = new();
        idle_on      = 1'b1;
        quiet_cycles = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_FIND;
        m_tready     = 1'b0;
        foreach (hot_set[i]) hot_set[i] = $urandom_range(0, SETS_DEF - 1);

        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed: all stamps equal, extremes of set and way, oldest moves on refill
        send_request(OP_FIND, 0, 0);
        send_request(OP_FIND, SETS_DEF - 1, WAYS_DEF - 1);
        send_request(OP_FILL, 0, 0);
        send_request(OP_FIND, 0, WAYS_DEF - 1);
        send_request(OP_FILL, 0, WAYS_DEF - 1);
        send_request(OP_FILL, 0, 0);
        send_request(OP_FIND, 0, 0);
        send_request(OP_FILL, SETS_DEF - 1, 0);
        send_request(OP_FIND, SETS_DEF - 1, 0);
        send_request(OP_FILL, SETS_DEF - 1, 1);
        send_request(OP_FILL, SETS_DEF - 1, 2);
        send_request(OP_FIND, SETS_DEF - 1, 9);
        send_request(OP_FILL, 42, 10);
        send_request(OP_FILL, 21, 5);
        send_request(OP_FIND, 42, 5);
        send_request(OP_FIND, 21, 10);
        send_request(OP_FIND, 0, 0);
        send_request(OP_FIND, 0, 0);
        send_request(OP_FILL, 0, 1);
        send_request(OP_FIND, 0, 0);

        // random traffic, mostly on a few hot sets so victims keep moving
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_on = !(i >= BURST_START && i < BURST_END);
            if ($urandom_range(0, 99) < 75)
                set_pick = hot_set[$urandom_range(0, 3)];
            else
                set_pick = $urandom_range(0, SETS_DEF - 1);
            send_request($urandom_range(0, 99) < 55 ? OP_FILL : OP_FIND, set_pick,
                         $urandom_range(0, WAYS_DEF - 1));
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        // drain outstanding results, then let the core settle
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        leftover = board.pending();

        if (board.failures == 0 && leftover == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fcr_pkg.sv
rtl/fcr_ram.sv
rtl/fcr_oldest.sv
rtl/fifo_cache_replacement_core.sv
sim/fifo_cache_replacement_core_test.sv
